/* hw/rtl/dwst_pkg.sv */
// Package for the debug watchpoint slot table.
// Commands, status codes, controller states, stream widths and the length encoder.
// No dependencies.
package dwst_pkg;

    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [1:0] {
        CMD_ARM        = 2'd0,
        CMD_DISARM     = 2'd1,
        CMD_DISARM_ALL = 2'd2,
        CMD_HIT        = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_BAD_LENGTH  = 4'd1,
        ST_MISALIGNED  = 4'd2,
        ST_EXEC_LENGTH = 4'd3,
        ST_IO          = 4'd4,
        ST_FULL        = 4'd5,
        ST_NOT_OURS    = 4'd6,
        ST_UNCLAIMED   = 4'd7,
        ST_BAD_SLOT    = 4'd8
    } status_t;

    localparam logic [1:0] KIND_EXEC = 2'b00;
    localparam logic [1:0] KIND_IO   = 2'b10;

    localparam logic [31:0] HIT_MAX   = 32'hFFFF_FFFF;
    // DR7 bits 9 and 10 are always set
    localparam logic [31:0] DR7_FIXED = 32'h0000_0600;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input transaction
        logic commit;    // update table, load result register
    } dp_cmd_t;

    // DR7 LEN encoding: 1->0, 2->1, 8->2, 4->3
    function automatic logic [1:0] length_code(input logic [7:0] bytes);
        logic [1:0] code;
        case (bytes)
            8'd2:    code = 2'b01;
            8'd8:    code = 2'b10;
            8'd4:    code = 2'b11;
            default: code = 2'b00;
        endcase
        return code;
    endfunction

endpackage

/* hw/rtl/dwst_ctrl.sv */
// Controller for the debug watchpoint slot table.
// Sequences capture and commit, owns the output valid flag. Uses dwst_pkg.
module dwst_ctrl
    import dwst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t dp_cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        dp_cmd.capture = 1'b0;
        dp_cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // result register free, or emptied this cycle
                if (!out_valid_reg || m_tready)
                begin
                    dp_cmd.commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (dp_cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* hw/rtl/dwst_datapath.sv */
// Datapath for the debug watchpoint slot table.
// Input latch, slot flops, arm/disarm/hit logic, DR7 rebuild, result register. Uses dwst_pkg.
module dwst_datapath
    import dwst_pkg::*;
#(
    parameter int SLOT_COUNT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     dp_cmd,
    input  logic [1:0]  command,
    input  logic [63:0] address,
    input  logic [7:0]  length_bytes,
    input  logic [1:0]  access_kind,
    input  logic        on_hit_action,
    input  logic [2:0]  slot_index,
    input  logic [3:0]  hit_bits,
    output logic [3:0]  status,
    output logic [1:0]  slot_used,
    output logic        was_armed,
    output logic        keep_running,
    output logic [31:0] hit_count,
    output logic [31:0] control_word
);

    // latched transaction
    cmd_t        command_reg;
    logic [63:0] address_reg;
    logic [7:0]  length_reg;
    logic [1:0]  kind_reg;
    logic        action_reg;
    logic [2:0]  sidx_reg;
    logic [3:0]  hits_reg;

    // slot table
    logic [SLOT_COUNT-1:0] armed_reg, armed_next;
    logic [63:0]           slot_address_reg [SLOT_COUNT];
    logic [1:0]            slot_len_reg     [SLOT_COUNT];
    logic [1:0]            slot_kind_reg    [SLOT_COUNT];
    logic                  slot_action_reg  [SLOT_COUNT];
    logic [31:0]           slot_hits_reg    [SLOT_COUNT];

    // control from the command decode
    logic [SLOT_COUNT-1:0] arm_mask;
    logic [SLOT_COUNT-1:0] hit_mask;
    logic [31:0]           hit_inc;

    // result register
    logic [3:0]  status_reg;
    logic [1:0]  used_reg;
    logic        was_reg;
    logic        keep_reg;
    logic [31:0] count_reg;
    logic [31:0] ctrl_word_reg;

    status_t     status_next;
    logic [1:0]  used_next;
    logic        was_next;
    logic        keep_next;
    logic [31:0] count_next;
    logic [31:0] ctrl_word_next;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            command_reg <= cmd_t'(command);
            address_reg <= address;
            length_reg  <= length_bytes;
            kind_reg    <= access_kind;
            action_reg  <= on_hit_action;
            sidx_reg    <= slot_index;
            hits_reg    <= hit_bits;
        end
    end

    always_comb
    begin
        logic                  len_ok;
        logic [3:0]            len_mask;
        logic                  free_found;
        logic [1:0]            free_idx;
        logic [SLOT_COUNT-1:0] free_mask;
        logic                  hit_found;
        logic [1:0]            hit_idx;
        logic                  hit_armed;
        logic [31:0]           hit_cur;
        logic                  hit_act;
        logic [1:0]            kind_n;
        logic [1:0]            len_n;

        len_ok   = (length_reg == 8'd1) || (length_reg == 8'd2) ||
                   (length_reg == 8'd4) || (length_reg == 8'd8);
        len_mask = length_reg[3:0] - 4'd1;

        // lowest free slot; loop runs downward so the lowest wins
        free_found = 1'b0;
        free_idx   = 2'd0;
        free_mask  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!armed_reg[i])
            begin
                free_found   = 1'b1;
                free_idx     = 2'(i);
                free_mask    = '0;
                free_mask[i] = 1'b1;
            end
        end

        // lowest set hit bit among implemented slots
        hit_found = 1'b0;
        hit_idx   = 2'd0;
        hit_armed = 1'b0;
        hit_cur   = '0;
        hit_act   = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (hits_reg[i])
            begin
                hit_found = 1'b1;
                hit_idx   = 2'(i);
                hit_armed = armed_reg[i];
                hit_cur   = slot_hits_reg[i];
                hit_act   = slot_action_reg[i];
            end
        end
        hit_inc = (hit_cur == HIT_MAX) ? hit_cur : hit_cur + 32'd1;

        armed_next  = armed_reg;
        arm_mask    = '0;
        hit_mask    = '0;
        status_next = ST_OK;
        used_next   = 2'd0;
        was_next    = 1'b0;
        keep_next   = 1'b0;
        count_next  = '0;

        case (command_reg)
            CMD_ARM:
            begin
                if (!len_ok)
                    status_next = ST_BAD_LENGTH;
                else if ((address_reg[3:0] & len_mask) != 4'd0)
                    status_next = ST_MISALIGNED;
                else if (kind_reg == KIND_EXEC && length_reg != 8'd1)
                    status_next = ST_EXEC_LENGTH;
                else if (kind_reg == KIND_IO)
                    status_next = ST_IO;
                else if (!free_found)
                    status_next = ST_FULL;
                else
                begin
                    arm_mask   = free_mask;
                    armed_next = armed_reg | free_mask;
                    used_next  = free_idx;
                end
            end
            CMD_DISARM:
            begin
                if (sidx_reg >= 3'(SLOT_COUNT))
                    status_next = ST_BAD_SLOT;
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (sidx_reg == 3'(i))
                        begin
                            was_next      = armed_reg[i];
                            armed_next[i] = 1'b0;
                        end
                    end
                    used_next = sidx_reg[1:0];
                end
            end
            CMD_DISARM_ALL:
            begin
                armed_next = '0;
            end
            CMD_HIT:
            begin
                if (hits_reg == 4'd0)
                    status_next = ST_NOT_OURS;
                else if (!hit_found || !hit_armed)
                    status_next = ST_UNCLAIMED;
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                        hit_mask[i] = (hit_idx == 2'(i));
                    count_next = hit_inc;
                    keep_next  = hit_act;
                    used_next  = hit_idx;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        // DR7 from the table as it stands after this command
        ctrl_word_next = DR7_FIXED;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            kind_n = arm_mask[i] ? kind_reg : slot_kind_reg[i];
            len_n  = arm_mask[i] ? length_code(length_reg) : slot_len_reg[i];
            if (armed_next[i])
            begin
                ctrl_word_next[2*i+1]              = 1'b1;
                ctrl_word_next[16+4*i +: 2]        = kind_n;
                ctrl_word_next[18+4*i +: 2]        = len_n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            armed_reg <= '0;
        else if (dp_cmd.commit)
            armed_reg <= armed_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (dp_cmd.commit && arm_mask[i])
            begin
                slot_address_reg[i] <= address_reg;
                slot_len_reg[i]     <= length_code(length_reg);
                slot_kind_reg[i]    <= kind_reg;
                slot_action_reg[i]  <= action_reg;
                slot_hits_reg[i]    <= '0;
            end
            else if (dp_cmd.commit && hit_mask[i])
            begin
                slot_hits_reg[i] <= hit_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit)
        begin
            status_reg    <= status_next;
            used_reg      <= used_next;
            was_reg       <= was_next;
            keep_reg      <= keep_next;
            count_reg     <= count_next;
            ctrl_word_reg <= ctrl_word_next;
        end
    end

    assign status       = status_reg;
    assign slot_used    = used_reg;
    assign was_armed    = was_reg;
    assign keep_running = keep_reg;
    assign hit_count    = count_reg;
    assign control_word = ctrl_word_reg;

endmodule

/* hw/rtl/debug_watchpoint_slot_table_core.sv */
// Top level of the debug watchpoint slot table.
// Instantiates dwst_ctrl and dwst_datapath; uses dwst_pkg.
//
// Channel | Dir | Handshake           | Content
// --------+-----+---------------------+---------------------------------------------
// s_*     | in  | s_tvalid / s_tready | one command transaction (tuser = command)
// m_*     | out | m_tvalid / m_tready | one result transaction per command
//
// Each command is latched in S_IDLE; S_EXEC then runs the decode, updates the
// slot flops, rebuilds DR7 and loads the result register. No new command is
// taken until S_EXEC has committed.
// A result waiting on m_tready does not block the next input latch; the commit of
// that next command waits until the result register is taken or freed that cycle.
// Reset (rst_n, async, low) clears the armed bits, the controller and m_tvalid;
// slot contents need no reset since only armed slots are ever read.
module debug_watchpoint_slot_table_core
    import dwst_pkg::*;
#(
    parameter int SLOT_COUNT = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // address[63:0], length_bytes[71:64], access_kind[73:72], on_hit_action[74],
    // slot_index[77:75], hit_bits[81:78], zero pad [87:82]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[3:0], slot_used[5:4], was_armed[6], keep_running[7],
    // hit_count[39:8], control_word[71:40]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    dp_cmd_t     dp_cmd;

    logic [3:0]  status;
    logic [1:0]  slot_used;
    logic        was_armed;
    logic        keep_running;
    logic [31:0] hit_count;
    logic [31:0] control_word;

    dwst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd)
    );

    dwst_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .command       (s_tuser[1:0]),
        .address       (s_tdata[63:0]),
        .length_bytes  (s_tdata[71:64]),
        .access_kind   (s_tdata[73:72]),
        .on_hit_action (s_tdata[74]),
        .slot_index    (s_tdata[77:75]),
        .hit_bits      (s_tdata[81:78]),
        .status        (status),
        .slot_used     (slot_used),
        .was_armed     (was_armed),
        .keep_running  (keep_running),
        .hit_count     (hit_count),
        .control_word  (control_word)
    );

    assign m_tdata = {control_word, hit_count, keep_running, was_armed, slot_used, status};

endmodule
